### hdl/twp_pkg.sv
package twp_pkg;

  // Data word: signed fixed point, FracBits fractional bits.
  localparam int WordW    = 32;
  localparam int FracBits = 16;

  // Saturating sums are formed this wide, then clamped to WordW.
  localparam int SumW = WordW + 3;

  // Serial divider: remainder / divisor width and step counter.
  localparam int DivW     = WordW + 1;
  localparam int DivCntW  = $clog2(DivW + 1);
  localparam int QuoW     = FracBits;

  // Serial multiplier: frac operand is 1.FracBits, product high part.
  localparam int MulW     = FracBits + 1;
  localparam int MulCntW  = $clog2(MulW + 1);
  localparam int OffW     = WordW + 2;

  // Configuration port.
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_START     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RAMP_END       = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_RESET_POSITION = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_RATE_MODE      = CfgIdxW'(3);

  // 1.0 in the word format.
  localparam logic [WordW-1:0] FxOne =
    {{(WordW-FracBits-1){1'b0}}, 1'b1, {FracBits{1'b0}}};

  localparam logic MODE_CONTROL = 1'b0;
  localparam logic MODE_SAMPLE  = 1'b1;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] steps;
  } div_ctrl_t;

  function automatic logic [WordW-1:0] sat_word(input logic [SumW-1:0] v);
    logic [WordW-1:0] r;
    if ((&v[SumW-1:WordW-1]) || (~|v[SumW-1:WordW-1])) begin
      r = v[WordW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hdl/twp_div.sv
module twp_div import twp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  div_ctrl_t       ctrl,
  input  logic [DivW-1:0] rem_init,
  input  logic [DivW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [QuoW-1:0] quotient,
  output logic [DivW-1:0] remainder
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0]    rem_r, rem_nxt;
  logic [DivW-1:0]    dvd_r, dvd_nxt;
  logic [DivW-1:0]    dvs_r, dvs_nxt;
  logic [QuoW-1:0]    quo_r, quo_nxt;

  logic [DivW:0] trial;
  logic [DivW:0] trial_sub;
  logic          fit;

  // Restoring division, one quotient bit per cycle, dividend shifted in MSB first.
  assign trial     = {rem_r, dvd_r[DivW-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fit       = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctrl.steps;
      rem_nxt  = rem_init;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fit ? trial_sub[DivW-1:0] : trial[DivW-1:0];
      dvd_nxt = {dvd_r[DivW-2:0], 1'b0};
      quo_nxt = {quo_r[QuoW-2:0], fit};
      cnt_nxt = cnt_r - DivCntW'(1);
      if (cnt_r == DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule

### hdl/twp_mul.sv
module twp_mul import twp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WordW-1:0] mcand,
  input  logic [MulW-1:0]  mplier,
  output logic             done,
  output logic [OffW-1:0]  product_hi
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [MulCntW-1:0] cnt_r, cnt_nxt;
  logic [WordW:0]     p_r, p_nxt;
  logic [MulW-1:0]    mlr_r, mlr_nxt;
  logic [WordW-1:0]   mcand_r, mcand_nxt;

  logic [WordW+1:0] sum;

  // Shift-add, multiplier LSB first; product low bits shift into mlr_r from the top.
  assign sum = {p_r[WordW], p_r} +
               (mlr_r[0] ? {{2{mcand_r[WordW-1]}}, mcand_r} : '0);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    mlr_nxt   = mlr_r;
    mcand_nxt = mcand_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MulCntW'(MulW);
      p_nxt     = '0;
      mlr_nxt   = mplier;
      mcand_nxt = mcand;
    end else if (busy_r) begin
      p_nxt   = sum[WordW+1:1];
      mlr_nxt = {sum[0], mlr_r[MulW-1:1]};
      cnt_nxt = cnt_r - MulCntW'(1);
      if (cnt_r == MulCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    mlr_r   <= mlr_nxt;
    mcand_r <= mcand_nxt;
  end

  // Product shifted right by FracBits (floor).
  assign product_hi = {p_r, mlr_r[MulW-1]};
  assign done       = done_r;

endmodule

### hdl/triggered_wrapping_phasor_top.sv
// Triggered wrapping phasor: a saturating Q16.16 ramp that adds step_rate per
// transfer, wraps into [ramp_start, ramp_end) by floor modulo (into
// (ramp_end, ramp_start] when the bounds are reversed) and jumps to
// reset_position when trigger_value crosses from <= 0 to > 0. Items are worked
// one at a time; the input is ready only while the sequencer is idle, and a
// result waits in the output register so the next item can be taken before it
// is drained. The work is done by one shared bit-serial divider (one bit per
// cycle) and one bit-serial multiplier. In sample-rate mode without a crossing
// the result is loaded in S_EMIT once the output register is free, and the
// wrap of the stored level then runs in S_WRAP and S_WDIV before the next
// transfer can come. A crossing in sample-rate mode puts the sub-sample divide
// (S_FDIV) and the multiply (S_MUL) in front of S_EMIT; they add the scaled
// step to reset_position. Control-rate mode wraps first, in S_WRAP and S_WDIV,
// and then loads the wrapped level in S_EMIT. When ramp_start equals ramp_end
// the wrap divide is skipped. A stalled output adds its stall to the item.
// Configuration writes are always ready and must be made only while no item is in flight.
module triggered_wrapping_phasor_top import twp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_trigger_value,
  input  logic signed [31:0] in_step_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_ramp_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FDIV = 6'b000010,
    S_MUL  = 6'b000100,
    S_EMIT = 6'b001000,
    S_WRAP = 6'b010000,
    S_WDIV = 6'b100000
  } state_t;

  // Configuration registers
  logic [WordW-1:0] ramp_start_r, ramp_end_r, reset_position_r;
  logic             rate_mode_r;

  // Sequencer and item state
  state_t           state_r, state_nxt;
  logic [WordW-1:0] prev_r, prev_nxt;     // previous trigger sample
  logic [WordW-1:0] level_r, level_nxt;   // ramp level carried between items
  logic [WordW-1:0] rate_r, rate_nxt;     // step rate of the item in flight
  logic [WordW-1:0] work_r, work_nxt;     // level being worked on
  logic [DivW-1:0]  range_r, range_nxt;   // end - start, latched for the wrap
  logic             diff_neg_r, diff_neg_nxt;
  logic             r_neg_r, r_neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_level_r, out_level_nxt;

  // Divider / multiplier hookup
  div_ctrl_t        div_ctrl;
  logic [DivW-1:0]  div_rem_init, div_dividend, div_divisor;
  logic             div_busy, div_done;
  logic [QuoW-1:0]  div_quo;
  logic [DivW-1:0]  div_rem;
  logic             mul_start, mul_done;
  logic [OffW-1:0]  mul_off;

  logic             accept;
  logic             crossing;
  logic [DivW-1:0]  neg_prev, den;
  logic [DivW-1:0]  diff, range_now;
  logic [DivW-1:0]  diff_abs, range_abs;
  logic [DivW:0]    m_trunc, m_floor;
  logic [DivW:0]    wrap_sum;
  logic [WordW-1:0] wrapped;
  logic             wrap_done;
  logic [SumW-1:0]  trig_sum, rate_sum;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Rising crossing: previous <= 0 and current > 0.
  assign crossing = (prev_r[WordW-1] || (prev_r == '0)) &&
                    !in_trigger_value[WordW-1] && (in_trigger_value != '0);

  // Sub-sample offset division: partial remainder starts at -prev, then
  // FracBits zero bits are brought down. den > -prev, so q < 1.0.
  assign neg_prev = DivW'(0) - {prev_r[WordW-1], prev_r};
  assign den      = {in_trigger_value[WordW-1], in_trigger_value} -
                    {prev_r[WordW-1], prev_r};

  // Wrap operands
  assign diff      = {work_r[WordW-1], work_r} - {ramp_start_r[WordW-1], ramp_start_r};
  assign range_now = {ramp_end_r[WordW-1], ramp_end_r} -
                     {ramp_start_r[WordW-1], ramp_start_r};
  assign diff_abs  = diff[DivW-1] ? (DivW'(0) - diff) : diff;
  assign range_abs = range_now[DivW-1] ? (DivW'(0) - range_now) : range_now;

  // Floor modulo from the magnitude remainder: take the dividend's sign,
  // then move into the divisor's sign by adding the range.
  assign m_trunc = diff_neg_r ? ((DivW+1)'(0) - {1'b0, div_rem}) : {1'b0, div_rem};
  assign m_floor = ((div_rem != '0) && (diff_neg_r != r_neg_r)) ?
                   (m_trunc + {range_r[DivW-1], range_r}) : m_trunc;
  assign wrap_sum = {{2{ramp_start_r[WordW-1]}}, ramp_start_r} + m_floor;
  assign wrapped  = (state_r == S_WDIV) ? wrap_sum[WordW-1:0] : ramp_start_r;

  assign wrap_done = ((state_r == S_WRAP) && (range_now == '0)) ||
                     ((state_r == S_WDIV) && div_done);

  assign trig_sum = {{3{reset_position_r[WordW-1]}}, reset_position_r} +
                    {mul_off[OffW-1], mul_off};
  assign rate_sum = {{3{work_r[WordW-1]}}, work_r} + {{3{rate_r[WordW-1]}}, rate_r};

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    level_nxt     = level_r;
    rate_nxt      = rate_r;
    work_nxt      = work_r;
    range_nxt     = range_r;
    diff_neg_nxt  = diff_neg_r;
    r_neg_nxt     = r_neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    div_ctrl.start = 1'b0;
    div_ctrl.steps = DivCntW'(FracBits);
    div_rem_init   = neg_prev;
    div_dividend   = '0;
    div_divisor    = den;
    mul_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          prev_nxt = in_trigger_value;
          rate_nxt = in_step_rate;
          if (rate_mode_r == MODE_SAMPLE) begin
            if (crossing) begin
              div_ctrl.start = 1'b1;
              state_nxt      = S_FDIV;
            end else begin
              work_nxt  = level_r;
              state_nxt = S_EMIT;
            end
          end else begin
            work_nxt  = crossing ? reset_position_r : level_r;
            state_nxt = S_WRAP;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          work_nxt  = sat_word(trig_sum);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = work_r;
          if (rate_mode_r == MODE_SAMPLE) begin
            work_nxt  = sat_word(rate_sum);
            state_nxt = S_WRAP;
          end else begin
            level_nxt = sat_word(rate_sum);
            state_nxt = S_IDLE;
          end
        end
      end
      S_WRAP: begin
        diff_neg_nxt = diff[DivW-1];
        r_neg_nxt    = range_now[DivW-1];
        range_nxt    = range_now;
        if (range_now != '0) begin
          div_ctrl.start = 1'b1;
          div_ctrl.steps = DivCntW'(DivW);
          div_rem_init   = '0;
          div_dividend   = diff_abs;
          div_divisor    = range_abs;
          state_nxt      = S_WDIV;
        end
      end
      S_WDIV: begin
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Wrap finished: sample-rate mode stores it, control-rate mode emits it.
    if (wrap_done) begin
      if (rate_mode_r == MODE_SAMPLE) begin
        level_nxt = wrapped;
        state_nxt = S_IDLE;
      end else begin
        work_nxt  = wrapped;
        state_nxt = S_EMIT;
      end
    end
  end

  twp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .rem_init  (div_rem_init),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // frac = 1.0 + q, always in [1.0, 2.0)
  twp_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .mcand      (rate_r),
    .mplier     ({1'b1, div_quo}),
    .done       (mul_done),
    .product_hi (mul_off)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_start_r     <= '0;
      ramp_end_r       <= FxOne;
      reset_position_r <= '0;
      rate_mode_r      <= MODE_SAMPLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RAMP_START:     ramp_start_r     <= cfg_data;
        CFG_RAMP_END:       ramp_end_r       <= cfg_data;
        CFG_RESET_POSITION: reset_position_r <= cfg_data;
        CFG_RATE_MODE:      rate_mode_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r      <= rate_nxt;
    work_r      <= work_nxt;
    range_r     <= range_nxt;
    diff_neg_r  <= diff_neg_nxt;
    r_neg_r     <= r_neg_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ramp_level = out_level_r;

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_FDIV) || (state_r == S_WDIV)))
    else $error("divider result outside a divide state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier result outside multiply state");

  a_div_idle_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && (state_nxt != S_EMIT)) |=> out_valid_r)
    else $error("result left emit without being presented");

endmodule

### test/tb_triggered_wrapping_phasor_top.sv
`timescale 1ns / 100ps

module tb_triggered_wrapping_phasor_top;
  import twp_pkg::*;

  // Word limits, kept wide for the model arithmetic and word-sized for stimulus
  localparam longint LvlMax = 64'sd2147483647;
  localparam longint LvlMin = -64'sd2147483648;
  localparam logic signed [31:0] WordMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] WordMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = FxOne;

  // Covers the worst item, plus the wrap tail after the result leaves
  localparam int SettleCycles = 120;
  localparam int RandPhases   = 10;
  localparam int PhaseItems   = 133;

  // Tracks trigger history and ramp level, and holds the levels still owed
  class phasor_tracker;
    longint lo_bound, hi_bound, jump_level;
    longint prev_trig, level;
    logic mode;
    logic signed [31:0] levels_due[$];
    int errors, samples, checked;
    int crossings[2];

    function new();
      lo_bound = 0;
      hi_bound = longint'(FxOne);
      jump_level = 0;
      mode = MODE_SAMPLE;
      prev_trig = 0;
      level = 0;
      errors = 0;
      samples = 0;
      checked = 0;
      crossings[0] = 0;
      crossings[1] = 0;
    endfunction

    function longint clamp(longint v);
      if (v > LvlMax) return LvlMax;
      if (v < LvlMin) return LvlMin;
      return v;
    endfunction

    // floor division, C-style truncation corrected toward minus infinity
    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
    endfunction

    // floor-modulo fold into the bounds; equal bounds pin to the start
    function longint wrap_level(longint x);
      longint span;
      span = hi_bound - lo_bound;
      if (span == 0) return lo_bound;
      return x - span * fdiv(x - lo_bound, span);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_RAMP_START:     lo_bound = longint'(signed'(data));
        CFG_RAMP_END:       hi_bound = longint'(signed'(data));
        CFG_RESET_POSITION: jump_level = longint'(signed'(data));
        CFG_RATE_MODE:      mode = data[0];
        default: ;
      endcase
    endfunction

    function void advance(logic signed [31:0] trig, logic signed [31:0] rate);
      longint cur, rt, one, q, frac, off, lvl;
      bit crossing;
      cur = trig;
      rt = rate;
      one = longint'(FxOne);
      lvl = level;
      crossing = (prev_trig <= 0) && (cur > 0);
      if (mode == MODE_SAMPLE) begin
        if (crossing) begin
          // sub-sample position of the crossing scales the first step
          q = fdiv(-prev_trig * one, cur - prev_trig);
          frac = one + q;
          off = fdiv(frac * rt, one);
          lvl = clamp(jump_level + off);
        end
        levels_due.push_back(lvl[31:0]);
        lvl = wrap_level(clamp(lvl + rt));
      end else begin
        if (crossing) lvl = jump_level;
        lvl = wrap_level(lvl);
        levels_due.push_back(lvl[31:0]);
        lvl = clamp(lvl + rt);
      end
      prev_trig = cur;
      level = lvl;
      samples++;
      if (crossing) crossings[mode]++;
    endfunction

    function void compare_level(logic signed [31:0] got);
      logic signed [31:0] want;
      if (levels_due.size() == 0) begin
        errors++;
        $display("%0t: ramp_level %0d (0x%08h) with no level expected", $time, got, got);
        return;
      end
      want = levels_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: ramp_level mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
                 $time, want, want, got, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_trigger_value;
  logic signed [31:0] in_step_rate;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_ramp_level;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  phasor_tracker trk = new();

  // Idle odds in percent per transfer, changed per phase; zero means steady
  int in_gap_pct = 20;
  int out_stall_pct = 20;
  int setups = 0;

  triggered_wrapping_phasor_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_trigger_value (in_trigger_value),
    .in_step_rate     (in_step_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ramp_level   (out_ramp_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake hangs or a level never shows up
  initial begin
    #8_000_000;
    $display("tb_triggered_wrapping_phasor_top NOT OK");
    $finish;
  end

  // Result side: check every transfer, stall out_ready in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) trk.compare_level(out_ramp_level);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Leaves cfg_valid high; the caller drops it once the batch is done
  task automatic send_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    trk.write_reg(idx, data);
  endtask

  // Registers only change with nothing in flight: drain, let the wrap tail
  // finish, then write all four plus one out-of-map index that must be ignored
  task automatic setup_ramp(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] jump, input logic [31:0] mode_word);
    in_valid <= 1'b0;
    while (trk.levels_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    send_reg(CFG_RAMP_START, lo);
    send_reg(CFG_RAMP_END, hi);
    send_reg(CFG_RESET_POSITION, jump);
    send_reg(CFG_RATE_MODE, mode_word);
    send_reg(CfgIdxW'($urandom_range(int'(CFG_RATE_MODE) + 1, (1 << CfgIdxW) - 1)),
             $urandom());
    cfg_valid <= 1'b0;
    setups++;
  endtask

  // One sample transfer; valid stays up into the next call unless a gap is drawn
  task automatic send_sample(input logic signed [31:0] trig, input logic signed [31:0] rate);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_trigger_value <= trig;
    in_step_rate     <= rate;
    do @(posedge clk); while (!in_ready);
    trk.advance(trig, rate);
  endtask

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return WordMin;
      1: return WordMax;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return QOne;
    endcase
  endfunction

  // Mostly small values around zero so rising crossings come often
  function automatic logic signed [31:0] pick_trigger();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return pick_edge();
      2: return $urandom();
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  // Rates of assorted magnitude, with the odd full-scale value to saturate
  function automatic logic signed [31:0] pick_rate();
    int span;
    case ($urandom_range(0, 9))
      0: return pick_edge();
      1: return $urandom();
      2: return 0;
      default: begin
        span = 1 << $urandom_range(4, 20);
        return $urandom_range(0, 2 * span) - span;
      end
    endcase
  endfunction

  initial begin
    int lo_w, hi_w, jump_w;
    logic [31:0] mode_word;

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_trigger_value <= '0;
    in_step_rate     <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_RAMP_START;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset bounds [0, 1.0), sample-rate: zero trigger, crossings from zero
    // and from below, full-scale values and rate saturation
    send_sample(0, 0);
    send_sample(QOne, QOne >>> 2);
    send_sample(-QOne, QOne >>> 2);
    send_sample(QOne, 32'sd49152);
    send_sample(WordMin, WordMax);
    send_sample(WordMax, WordMin);
    send_sample(WordMin, WordMin);
    send_sample(0, -1);
    send_sample(1, 1);

    // Control-rate with junk in the upper mode bits; jump target above the
    // bounds so it has to be folded back in
    setup_ramp(-3 * QOne, 2 * QOne, WordMax, {31'h7fff_ffff, MODE_CONTROL});
    send_sample(WordMin, 0);
    send_sample(WordMax, QOne);
    send_sample(0, WordMax);
    send_sample(-5, WordMin);
    send_sample(5, 3 * (QOne >>> 1));
    send_sample(0, -QOne);

    // Sample-rate, jump target outside the bounds: the reset level goes out
    // unwrapped
    setup_ramp(-QOne, QOne, 5 * QOne, {1'b1, 30'b0, MODE_SAMPLE});
    send_sample(-QOne, QOne >>> 3);
    send_sample(QOne >>> 1, QOne >>> 3);
    send_sample(-7, -QOne);

    // Equal bounds always fold to the start
    setup_ramp(3 * QOne, 3 * QOne, -QOne, {31'b0, MODE_CONTROL});
    send_sample(QOne, QOne);
    send_sample(-QOne, WordMax);

    // Reversed bounds; crossing with a negative rate drives the jump to the floor
    setup_ramp(2 * QOne, -QOne, WordMin, {31'b0, MODE_SAMPLE});
    send_sample(QOne, -QOne);
    send_sample(-1, 5 * QOne);

    // Full-scale span
    setup_ramp(WordMin, WordMax, 0, {31'b0, MODE_CONTROL});
    send_sample(QOne, WordMax);
    send_sample(0, WordMax);

    // Random phases, each with a fresh setup; phase 3 and the last two run without idling
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph >= RandPhases - 2 || ph == 3) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct = $urandom_range(5, 35);
        out_stall_pct = $urandom_range(5, 35);
      end
      lo_w = $urandom_range(0, 1 << 19) - (1 << 18);
      case (ph % 6)
        0: hi_w = lo_w + $urandom_range(1, 1 << 19);
        1: hi_w = lo_w;
        2: hi_w = lo_w - $urandom_range(1, 1 << 19);
        3: begin
          lo_w = WordMin;
          hi_w = WordMax;
        end
        4: begin
          lo_w = WordMax;
          hi_w = WordMin;
        end
        default: begin
          lo_w = $urandom();
          hi_w = $urandom();
        end
      endcase
      case ($urandom_range(0, 3))
        0: jump_w = $urandom_range(0, 1 << 20) - (1 << 19);
        1: jump_w = WordMin;
        2: jump_w = WordMax;
        default: jump_w = $urandom();
      endcase
      mode_word = $urandom();
      mode_word[0] = ph[0];
      setup_ramp(lo_w, hi_w, jump_w, mode_word);
      repeat (PhaseItems) send_sample(pick_trigger(), pick_rate());
    end

    in_valid <= 1'b0;
    while (trk.levels_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d samples over %0d ramp setups (normal, equal, reversed, full-scale bounds)",
             trk.samples, setups + 1);
    $display("trigger crossings: %0d control-rate, %0d sample-rate; %0d levels checked",
             trk.crossings[0], trk.crossings[1], trk.checked);
    if (trk.errors == 0) begin
      $display("tb_triggered_wrapping_phasor_top OK");
    end else begin
      $display("tb_triggered_wrapping_phasor_top NOT OK");
    end
    $finish;
  end

endmodule
